[rtl/core/brfwr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfwr_pkg
// Shared types, codes and helpers of the byte ring fifo with wrap regions.
// ----------------------------------------------------------------------------
package brfwr_pkg;

    localparam int unsigned DEF_MAX_DEPTH      = 4096;
    localparam int unsigned DEF_MAX_READ_BURST = 64;
    localparam logic [3:0]  LG_LIMIT           = 4'd12;

    // request codes on the input port
    localparam logic [2:0] REQ_STORE   = 3'd0;
    localparam logic [2:0] REQ_ADVANCE = 3'd1;
    localparam logic [2:0] REQ_READ    = 3'd2;
    localparam logic [2:0] REQ_QUERY   = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_CLAMP = 2'd2;

    typedef enum logic [2:0] {
        OP_STORE   = 3'd0,
        OP_ADVANCE = 3'd1,
        OP_READ    = 3'd2,
        OP_QUERY   = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_NOP     = 3'd5
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [11:0] offset;
        logic [12:0] amount;
    } t_cmd;

    function automatic int unsigned floor_log2(input int unsigned v);
        int unsigned r;
        r = 0;
        for (int i = 1; i < 32; i++) begin
            if ((v >> i) != 0) r = i;
        end
        return r;
    endfunction

    // clamp the register value to 1..12, then to the largest store size
    function automatic logic [3:0] eff_lg(input logic [3:0] v, input logic [3:0] lg_max);
        logic [3:0] r;
        r = v;
        if (r < 4'd1) r = 4'd1;
        if (r > LG_LIMIT) r = LG_LIMIT;
        if (r > lg_max) r = lg_max;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/brfwr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfwr_front
// Accepts requests, decodes the request code and holds them in a two-entry
// command queue for the back end.
// ----------------------------------------------------------------------------
module brfwr_front import brfwr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [11:0] i_store_offset,
    input  wire logic [12:0] i_amount,
    output logic             busy,
    output logic             o_head_vld,
    output t_cmd             o_head,
    input  wire logic        i_pop
);

    t_cmd       r_q [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_cmd       cmd;

    assign busy       = (r_cnt == 2'd2);
    assign push       = start && !busy;
    assign o_head_vld = (r_cnt != 2'd0);
    assign o_head     = r_q[r_rd];

    always_comb begin
        cmd.data   = i_data_byte;
        cmd.offset = i_store_offset;
        cmd.amount = i_amount;
        unique case (i_req_type)
            REQ_STORE:   cmd.op = OP_STORE;
            REQ_ADVANCE: cmd.op = OP_ADVANCE;
            REQ_READ:    cmd.op = OP_READ;
            REQ_QUERY:   cmd.op = OP_QUERY;
            REQ_CLEAR:   cmd.op = OP_CLEAR;
            default:     cmd.op = OP_NOP;
        endcase
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = !r_wr;
        end
        if (i_pop && o_head_vld) begin
            n_rd = !r_rd;
        end
        priority if (push && !(i_pop && o_head_vld)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop && o_head_vld) begin
            n_cnt = r_cnt - 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd;
        end
    end

endmodule
`default_nettype wire

[rtl/core/brfwr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfwr_back
// Executes queued commands against the byte store and the ring pointers and
// drives the registered result ports. Reads stream one byte per cycle.
// ----------------------------------------------------------------------------
module brfwr_back import brfwr_pkg::*; #(
    parameter int unsigned MAX_DEPTH      = DEF_MAX_DEPTH,
    parameter int unsigned MAX_READ_BURST = DEF_MAX_READ_BURST
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        i_head_vld,
    input  wire t_cmd        i_head,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [7:0]       o_byte_out,
    output logic             o_last,
    output logic [12:0]      o_moved_count,
    output logic [1:0]       o_region_count,
    output logic [11:0]      o_region_start,
    output logic [12:0]      o_second_length,
    output logic [12:0]      o_used_bytes,
    output logic [12:0]      o_free_bytes
);

    localparam int unsigned DEPTH_LIM = (MAX_DEPTH < 4096) ? MAX_DEPTH : 4096;
    localparam int unsigned AW        = floor_log2(DEPTH_LIM);
    localparam int unsigned DEPTH     = 1 << AW;
    localparam logic [3:0]  LG_MAX    = 4'(AW);
    localparam int unsigned KW        = $clog2(MAX_READ_BURST + 1);
    localparam logic [12:0] BURST_MAX = 13'(MAX_READ_BURST);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_mem_q;

    t_state        r_state, n_state;
    logic [3:0]    r_lg, n_lg;
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [AW-1:0] r_raddr, n_raddr;
    logic [12:0]   r_used, n_used;
    logic [12:0]   r_free, n_free;
    logic [KW-1:0] r_left, n_left;
    logic [KW-1:0] r_n, n_n;

    logic          r_o_vld, n_o_vld;
    logic [1:0]    r_o_status, n_o_status;
    logic          r_o_last, n_o_last;
    logic          r_o_isbyte, n_o_isbyte;
    logic [12:0]   r_o_moved, n_o_moved;
    logic [1:0]    r_o_rcount, n_o_rcount;
    logic [11:0]   r_o_rstart, n_o_rstart;
    logic [12:0]   r_o_second, n_o_second;
    logic [12:0]   r_o_used, n_o_used;
    logic [12:0]   r_o_free, n_o_free;

    logic [12:0]   cap;
    logic [AW-1:0] imask;
    logic [3:0]    cfg_lg;
    logic [AW-1:0] waddr;
    logic          mem_we;
    logic          mem_re;
    logic [12:0]   adv_n;
    logic [12:0]   rd_n;
    logic [12:0]   qf;
    logic [12:0]   to_end;

    assign cap    = 13'd1 << r_lg;
    assign imask  = AW'(cap - 13'd1);
    assign cfg_lg = eff_lg(i_cfg_wdata, LG_MAX);
    assign o_pop  = (r_state == S_IDLE) && i_head_vld;
    assign waddr  = (r_wptr + i_head.offset[AW-1:0]) & imask;
    assign mem_we = o_pop && (i_head.op == OP_STORE) && ({1'b0, i_head.offset} < r_free);

    always_comb begin
        adv_n = (i_head.amount > r_free) ? r_free : i_head.amount;
        rd_n  = (i_head.amount > BURST_MAX) ? BURST_MAX : i_head.amount;
        if (rd_n > r_used) rd_n = r_used;
        qf     = (i_head.amount > r_free) ? r_free : i_head.amount;
        to_end = cap - 13'(r_wptr);
    end

    always_comb begin
        n_state    = r_state;
        n_lg       = r_lg;
        n_wptr     = r_wptr;
        n_rptr     = r_rptr;
        n_raddr    = r_raddr;
        n_used     = r_used;
        n_free     = r_free;
        n_left     = r_left;
        n_n        = r_n;
        mem_re     = 1'b0;
        n_o_vld    = 1'b0;
        n_o_status = ST_OK;
        n_o_last   = 1'b1;
        n_o_isbyte = 1'b0;
        n_o_moved  = 13'd0;
        n_o_rcount = 2'd0;
        n_o_rstart = 12'd0;
        n_o_second = 13'd0;
        n_o_used   = r_used;
        n_o_free   = r_free;

        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_o_vld = 1'b1;
                    unique case (i_head.op)
                        OP_STORE: begin
                            if (!mem_we) n_o_status = ST_NONE;
                        end
                        OP_ADVANCE: begin
                            if (i_head.amount > r_free) n_o_status = ST_CLAMP;
                            n_o_moved = adv_n;
                            n_wptr    = (r_wptr + adv_n[AW-1:0]) & imask;
                            n_used    = r_used + adv_n;
                            n_free    = r_free - adv_n;
                            n_o_used  = r_used + adv_n;
                            n_o_free  = r_free - adv_n;
                        end
                        OP_READ: begin
                            priority if (r_used == 13'd0) begin
                                n_o_status = ST_NONE;
                            end else if (rd_n == 13'd0) begin
                                n_o_status = ST_OK;
                            end else begin
                                // counters move now; bytes stream in the read state
                                n_o_vld = 1'b0;
                                n_rptr  = (r_rptr + AW'(rd_n)) & imask;
                                n_raddr = r_rptr;
                                n_used  = r_used - rd_n;
                                n_free  = r_free + rd_n;
                                n_left  = KW'(rd_n);
                                n_n     = KW'(rd_n);
                                n_state = S_READ;
                            end
                        end
                        OP_QUERY: begin
                            n_o_rstart = 12'(r_wptr);
                            priority if (qf == 13'd0) begin
                                n_o_status = ST_NONE;
                            end else if (qf <= to_end) begin
                                n_o_moved  = qf;
                                n_o_rcount = 2'd1;
                            end else begin
                                n_o_moved  = to_end;
                                n_o_rcount = 2'd2;
                                n_o_second = qf - to_end;
                            end
                        end
                        OP_CLEAR: begin
                            n_wptr   = '0;
                            n_rptr   = '0;
                            n_used   = 13'd0;
                            n_free   = cap;
                            n_o_used = 13'd0;
                            n_o_free = cap;
                        end
                        default: begin
                            n_o_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                mem_re     = 1'b1;
                n_o_vld    = 1'b1;
                n_o_isbyte = 1'b1;
                n_o_last   = (r_left == KW'(1));
                n_o_moved  = 13'(r_n);
                n_raddr    = (r_raddr + AW'(1)) & imask;
                n_left     = r_left - KW'(1);
                if (r_left == KW'(1)) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // the user must write the register only while idle, which the block leaves unchecked; it empties the buffer
        if (i_cfg_we) begin
            n_lg   = cfg_lg;
            n_wptr = '0;
            n_rptr = '0;
            n_used = 13'd0;
            n_free = 13'd1 << cfg_lg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lg    <= eff_lg(LG_LIMIT, LG_MAX);
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_used  <= 13'd0;
            r_free  <= 13'd1 << eff_lg(LG_LIMIT, LG_MAX);
            r_left  <= '0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lg    <= n_lg;
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_used  <= n_used;
            r_free  <= n_free;
            r_left  <= n_left;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr    <= n_raddr;
        r_n        <= n_n;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
        r_o_isbyte <= n_o_isbyte;
        r_o_moved  <= n_o_moved;
        r_o_rcount <= n_o_rcount;
        r_o_rstart <= n_o_rstart;
        r_o_second <= n_o_second;
        r_o_used   <= n_o_used;
        r_o_free   <= n_o_free;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= i_head.data;
        end
        if (mem_re) begin
            r_mem_q <= mem[r_raddr];
        end
    end

    assign o_strobe        = r_o_vld;
    assign o_status        = r_o_status;
    assign o_byte_out      = r_o_isbyte ? r_mem_q : 8'd0;
    assign o_last          = r_o_last;
    assign o_moved_count   = r_o_moved;
    assign o_region_count  = r_o_rcount;
    assign o_region_start  = r_o_rstart;
    assign o_second_length = r_o_second;
    assign o_used_bytes    = r_o_used;
    assign o_free_bytes    = r_o_free;

endmodule
`default_nettype wire

[rtl/core/byte_ring_fifo_with_wrap_regions_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_wrap_regions_top
// Byte ring buffer with free-running pointers and wrap-split writable regions.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low and goes into a
// two-entry command queue; busy is high only while that queue is full. The
// execution side handles a store, advance, region query, clear or unknown
// code without entering the read state, so these sustain one request per
// cycle while no read burst holds the back end. A read of n bytes (n up to
// MAX_READ_BURST) streams one byte per cycle from the single read port of the
// byte store, once the idle state has moved the counters and entered the read
// state. Each result is shown for one cycle with o_strobe and cannot be held
// off by the receiver. A write of the capacity register empties the buffer and
// must be done while no request is pending.
module byte_ring_fifo_with_wrap_regions_top import brfwr_pkg::*; #(
    parameter int unsigned MAX_DEPTH      = DEF_MAX_DEPTH,
    parameter int unsigned MAX_READ_BURST = DEF_MAX_READ_BURST
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [11:0] i_store_offset,
    input  wire logic [12:0] i_amount,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [7:0]       o_byte_out,
    output logic             o_last,
    output logic [12:0]      o_moved_count,
    output logic [1:0]       o_region_count,
    output logic [11:0]      o_region_start,
    output logic [12:0]      o_second_length,
    output logic [12:0]      o_used_bytes,
    output logic [12:0]      o_free_bytes
);

    logic head_vld;
    t_cmd head;
    logic pop;

    brfwr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_req_type     (i_req_type),
        .i_data_byte    (i_data_byte),
        .i_store_offset (i_store_offset),
        .i_amount       (i_amount),
        .busy           (busy),
        .o_head_vld     (head_vld),
        .o_head         (head),
        .i_pop          (pop)
    );

    brfwr_back #(
        .MAX_DEPTH      (MAX_DEPTH),
        .MAX_READ_BURST (MAX_READ_BURST)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_head_vld      (head_vld),
        .i_head          (head),
        .o_pop           (pop),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_byte_out      (o_byte_out),
        .o_last          (o_last),
        .o_moved_count   (o_moved_count),
        .o_region_count  (o_region_count),
        .o_region_start  (o_region_start),
        .o_second_length (o_second_length),
        .o_used_bytes    (o_used_bytes),
        .o_free_bytes    (o_free_bytes)
    );

endmodule
`default_nettype wire

[rtl/core/brfwr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfwr_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module brfwr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_strobe,
    input wire logic [1:0]  o_status,
    input wire logic        o_last,
    input wire logic [12:0] o_moved_count,
    input wire logic [1:0]  o_region_count,
    input wire logic [12:0] o_second_length,
    input wire logic [12:0] o_used_bytes,
    input wire logic [12:0] o_free_bytes
);

    // no result straight out of reset
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    // used plus free never exceeds the largest capacity
    a_space_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ({1'b0, o_used_bytes} + {1'b0, o_free_bytes}) <= 14'd4096)
        else $error("used plus free beyond capacity");

    // a read burst continues without gaps until its last byte
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside a read burst");

    // a non-final result belongs to a successful multi-byte read
    a_burst_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (o_status == 2'd0) && (o_moved_count > 13'd1))
        else $error("bad non-final result");

    // two regions always come with a nonzero second length
    a_two_regions: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_region_count == 2'd2)) |-> (o_second_length != 13'd0))
        else $error("two regions with empty second region");

endmodule

bind byte_ring_fifo_with_wrap_regions_top brfwr_checker u_brfwr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_last          (o_last),
    .o_moved_count   (o_moved_count),
    .o_region_count  (o_region_count),
    .o_second_length (o_second_length),
    .o_used_bytes    (o_used_bytes),
    .o_free_bytes    (o_free_bytes)
);
`default_nettype wire
